FILE: rtl/core/i2cmte_pkg.sv
// Package for the I2C master transaction engine.
// Holds opcodes, status codes, state encodings and the item and result types.
// No dependencies.
package i2cmte_pkg;

   localparam int MaxBurst = 64;
   localparam int BufAw    = $clog2(MaxBurst);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RETRY = 2'd1;
   localparam logic [1:0] ST_NACK  = 2'd2;

   localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD = 2'd1;

   typedef enum logic [19:0] {
      PH_IDLE    = 20'h00001,
      PH_RS_A    = 20'h00002,
      PH_ST_A    = 20'h00004,
      PH_ST_B    = 20'h00008,
      PH_TX_LO   = 20'h00010,
      PH_TX_HI   = 20'h00020,
      PH_ACK_LO  = 20'h00040,
      PH_ACK_HI  = 20'h00080,
      PH_ACK_END = 20'h00100,
      PH_RX_LO   = 20'h00200,
      PH_RX_HI   = 20'h00400,
      PH_MA_LO   = 20'h00800,
      PH_MA_HI   = 20'h01000,
      PH_MA_END  = 20'h02000,
      PH_NA_LO   = 20'h04000,
      PH_NA_HI   = 20'h08000,
      PH_NA_END  = 20'h10000,
      PH_SP_A    = 20'h20000,
      PH_SP_B    = 20'h40000,
      PH_SP_C    = 20'h80000
   } phase_type;

   typedef enum logic [4:0] {
      SG_DEV  = 5'b00001,
      SG_RHI  = 5'b00010,
      SG_RLO  = 5'b00100,
      SG_RDEV = 5'b01000,
      SG_DATA = 5'b10000
   } stage_type;

   typedef enum logic [1:0] {
      SK_OK    = 2'd0,
      SK_ERR   = 2'd2,
      SK_RETRY = 2'd3
   } stop_kind_type;

   // Classified input item
   typedef struct packed {
      logic        is_tick;
      logic        is_load;
      logic        is_start;
      logic [7:0]  dev;
      logic [15:0] reg_addr;
      logic        wide;
      logic [6:0]  count;
      logic [7:0]  data;
      logic        sda;
   } item_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [6:0] acked_count;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       last_byte;
   } rsp_type;

   // Handshake between the command queue and the bus engine
   typedef struct packed {
      logic empty;
      logic pop;
   } link_type;

endpackage

FILE: rtl/core/i2cmte_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
// Depends on i2cmte_pkg.
module i2cmte_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           opcode,
   input  logic [7:0]           dev_addr,
   input  logic [15:0]          reg_addr,
   input  logic                 wide_addr,
   input  logic [6:0]           byte_count,
   input  logic [7:0]           data_byte,
   input  logic                 sda_sample,
   input  logic                 pop,
   output logic                 empty,
   output i2cmte_pkg::item_type item
);
   import i2cmte_pkg::*;

   item_type   entry_ff [2];
   item_type   cls;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   // Decode opcode, saturate count, force direction bit
   always_comb begin
      cls          = '0;
      cls.is_tick  = (opcode == OP_TICK);
      cls.is_load  = (opcode == OP_LOAD);
      cls.is_start = (opcode == OP_WRITE) || (opcode == OP_READ);
      cls.dev      = {dev_addr[7:1], opcode == OP_READ};
      cls.reg_addr = reg_addr;
      cls.wide     = wide_addr;
      cls.count    = (byte_count > 7'(MaxBurst)) ? 7'(MaxBurst) : byte_count;
      cls.data     = data_byte;
      cls.sda      = sda_sample;
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign item  = entry_ff[rd_ptr_ff];
   assign do_wr = push && !full;
   assign do_rd = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/core/i2cmte_rsp_queue.sv
// Result queue: two entries between the bus engine and the result port.
// Depends on i2cmte_pkg.
module i2cmte_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cmte_pkg::rsp_type din,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output i2cmte_pkg::rsp_type dout
);
   import i2cmte_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign dout  = entry_ff[rd_ptr_ff];
   assign do_wr = push && !full;
   assign do_rd = pop && !empty;
   assign count_in = count_ff + 2'(do_wr) - 2'(do_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_wr;
         rd_ptr_ff <= rd_ptr_ff ^ do_rd;
         count_ff  <= count_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

FILE: rtl/core/i2cmte_engine.sv
// Bus engine: runs the I2C transaction sequencer one item per step.
// Holds the write buffer memory. Depends on i2cmte_pkg.
module i2cmte_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           retry_limit,
   input  logic [15:0]          half_period_ticks,
   input  i2cmte_pkg::link_type link_in,
   output logic                 link_pop,
   input  i2cmte_pkg::item_type item,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output i2cmte_pkg::rsp_type  rsp
);
   import i2cmte_pkg::*;

   phase_type     phase_ff, phase_in;
   stage_type     stage_ff, stage_in;
   stop_kind_type stop_ff, stop_in;
   logic [15:0]   tick_ff, tick_in, tick_next, half_eff;
   logic [2:0]    bit_ff, bit_in;
   logic [7:0]    shift_ff, shift_in;
   logic [6:0]    byte_idx_ff, byte_idx_in;
   logic [7:0]    retry_ff, retry_in;
   logic [7:0]    dev_ff, dev_in;
   logic [15:0]   reg_ff, reg_in;
   logic          wide_ff, wide_in;
   logic [6:0]    count_ff, count_in;
   logic [6:0]    fill_ff, fill_in;
   logic [6:0]    ack_ff, ack_in;

   logic [7:0]    buf_mem [MaxBurst];
   logic [7:0]    rd_data_ff;
   logic [6:0]    rd_idx;
   logic          wr_en;

   logic          step, do_adv, do_try, fin, ok;
   logic [1:0]    fin_st;
   logic          rvalid, last;
   logic [7:0]    rbyte;
   logic          scl, sdal, tx_bit;

   assign step     = !link_in.empty && !rsp_full;
   assign link_pop = step;
   assign rsp_push = step;
   assign half_eff = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
   assign ok       = (shift_ff == 8'd0);

   // Step the sequencer
   always_comb begin
      phase_in    = phase_ff;
      stage_in    = stage_ff;
      stop_in     = stop_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      byte_idx_in = byte_idx_ff;
      retry_in    = retry_ff;
      dev_in      = dev_ff;
      reg_in      = reg_ff;
      wide_in     = wide_ff;
      count_in    = count_ff;
      fill_in     = fill_ff;
      ack_in      = ack_ff;
      tick_next   = tick_ff + 16'd1;
      wr_en       = 1'b0;
      do_adv      = 1'b0;
      do_try      = 1'b0;
      fin         = 1'b0;
      fin_st      = ST_OK;
      rvalid      = 1'b0;
      rbyte       = 8'd0;
      last        = 1'b0;

      if (step) begin
         if (item.is_tick) begin
            if (phase_ff != PH_IDLE) begin
               if (tick_next >= half_eff) begin
                  tick_in = 16'd0;
                  do_adv  = 1'b1;
               end else begin
                  tick_in = tick_next;
               end
            end
         end else if (phase_ff == PH_IDLE) begin
            if (item.is_load) begin
               if (fill_ff < 7'(MaxBurst)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 7'd1;
               end
            end else begin
               dev_in   = item.dev;
               reg_in   = item.reg_addr;
               wide_in  = item.wide;
               count_in = item.count;
               retry_in = 8'd0;
               do_try   = 1'b1;
            end
         end
      end

      // Advance one half period
      if (do_adv) begin
         case (phase_ff)
            PH_RS_A: phase_in = PH_ST_A;
            PH_ST_A: phase_in = PH_ST_B;
            PH_ST_B: begin
               shift_in = (stage_ff == SG_RDEV) ? {dev_ff[7:1], 1'b1} : {dev_ff[7:1], 1'b0};
               bit_in   = 3'd7;
               phase_in = PH_TX_LO;
            end
            PH_TX_LO: phase_in = PH_TX_HI;
            PH_TX_HI: begin
               if (bit_ff == 3'd0) begin
                  phase_in = PH_ACK_LO;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  phase_in = PH_TX_LO;
               end
            end
            PH_ACK_LO: phase_in = PH_ACK_HI;
            PH_ACK_HI: begin
               shift_in = {7'd0, item.sda};
               phase_in = PH_ACK_END;
            end
            PH_ACK_END: begin
               case (stage_ff)
                  SG_DEV: begin
                     if (!ok) begin
                        stop_in  = SK_RETRY;
                        phase_in = PH_SP_A;
                     end else begin
                        stage_in = wide_ff ? SG_RHI : SG_RLO;
                        shift_in = wide_ff ? reg_ff[15:8] : reg_ff[7:0];
                        bit_in   = 3'd7;
                        phase_in = PH_TX_LO;
                     end
                  end
                  SG_RHI: begin
                     if (!ok) begin
                        stop_in  = SK_ERR;
                        phase_in = PH_SP_A;
                     end else begin
                        ack_in   = ack_ff + 7'd1;
                        stage_in = SG_RLO;
                        shift_in = reg_ff[7:0];
                        bit_in   = 3'd7;
                        phase_in = PH_TX_LO;
                     end
                  end
                  SG_RLO: begin
                     if (!ok) begin
                        stop_in  = wide_ff ? SK_ERR : SK_RETRY;
                        phase_in = PH_SP_A;
                     end else begin
                        if (wide_ff) begin
                           ack_in = ack_ff + 7'd1;
                        end
                        if (dev_ff[0]) begin
                           stage_in = SG_RDEV;
                           phase_in = PH_RS_A;
                        end else begin
                           stage_in = SG_DATA;
                           if (byte_idx_ff >= count_ff) begin
                              stop_in  = SK_OK;
                              phase_in = PH_SP_A;
                           end else begin
                              shift_in = rd_data_ff;
                              bit_in   = 3'd7;
                              phase_in = PH_TX_LO;
                           end
                        end
                     end
                  end
                  SG_RDEV: begin
                     if (!ok) begin
                        stop_in  = SK_RETRY;
                        phase_in = PH_SP_A;
                     end else if (count_ff == 7'd0) begin
                        stop_in  = SK_OK;
                        phase_in = PH_SP_A;
                     end else begin
                        shift_in = 8'd0;
                        bit_in   = 3'd7;
                        phase_in = PH_RX_LO;
                     end
                  end
                  default: begin
                     if (!ok) begin
                        stop_in  = SK_ERR;
                        phase_in = PH_SP_A;
                     end else begin
                        ack_in      = ack_ff + 7'd1;
                        byte_idx_in = byte_idx_ff + 7'd1;
                        stage_in    = SG_DATA;
                        if (byte_idx_in >= count_ff) begin
                           stop_in  = SK_OK;
                           phase_in = PH_SP_A;
                        end else begin
                           shift_in = rd_data_ff;
                           bit_in   = 3'd7;
                           phase_in = PH_TX_LO;
                        end
                     end
                  end
               endcase
            end
            PH_RX_LO: phase_in = PH_RX_HI;
            PH_RX_HI: begin
               shift_in = {shift_ff[6:0], item.sda};
               if (bit_ff == 3'd0) begin
                  ack_in      = ack_ff + 7'd1;
                  byte_idx_in = byte_idx_ff + 7'd1;
                  rvalid      = 1'b1;
                  rbyte       = shift_in;
                  last        = (byte_idx_in >= count_ff);
                  phase_in    = last ? PH_NA_LO : PH_MA_LO;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  phase_in = PH_RX_LO;
               end
            end
            PH_MA_LO: phase_in = PH_MA_HI;
            PH_MA_HI: phase_in = PH_MA_END;
            PH_MA_END: begin
               shift_in = 8'd0;
               bit_in   = 3'd7;
               phase_in = PH_RX_LO;
            end
            PH_NA_LO: phase_in = PH_NA_HI;
            PH_NA_HI: phase_in = PH_NA_END;
            PH_NA_END: begin
               stop_in  = SK_OK;
               phase_in = PH_SP_A;
            end
            PH_SP_A: phase_in = PH_SP_B;
            PH_SP_B: phase_in = PH_SP_C;
            PH_SP_C: begin
               if (stop_ff == SK_RETRY) begin
                  do_try = 1'b1;
               end else begin
                  fin    = 1'b1;
                  fin_st = (stop_ff == SK_ERR) ? ST_NACK : ST_OK;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // Start a fresh attempt or give up
      if (do_try) begin
         if (retry_in >= retry_limit) begin
            fin    = 1'b1;
            fin_st = ST_RETRY;
         end else begin
            retry_in    = retry_in + 8'd1;
            ack_in      = 7'd0;
            byte_idx_in = 7'd0;
            stage_in    = SG_DEV;
            tick_in     = 16'd0;
            phase_in    = PH_ST_A;
         end
      end

      // Finish the transaction; a write empties the buffer
      if (fin) begin
         phase_in = PH_IDLE;
         tick_in  = 16'd0;
         if (!dev_in[0]) begin
            fill_in = 7'd0;
         end
      end
   end

   // Line drive after the step
   always_comb begin
      tx_bit = shift_in[bit_in];
      case (phase_in)
         PH_RS_A, PH_ACK_LO, PH_RX_LO, PH_NA_LO, PH_NA_END: begin
            scl  = 1'b1;
            sdal = 1'b0;
         end
         PH_ST_B, PH_MA_HI, PH_SP_B: begin
            scl  = 1'b0;
            sdal = 1'b1;
         end
         PH_TX_LO: begin
            scl  = 1'b1;
            sdal = ~tx_bit;
         end
         PH_TX_HI: begin
            scl  = 1'b0;
            sdal = ~tx_bit;
         end
         PH_ACK_END, PH_MA_LO, PH_MA_END, PH_SP_A: begin
            scl  = 1'b1;
            sdal = 1'b1;
         end
         default: begin
            scl  = 1'b0;
            sdal = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp.scl_drive_low = scl;
      rsp.sda_drive_low = sdal;
      rsp.busy_res      = (phase_in != PH_IDLE);
      rsp.done_res      = fin;
      rsp.status        = fin ? fin_st : ST_OK;
      rsp.acked_count   = fin ? ack_in : 7'd0;
      rsp.read_valid    = rvalid;
      rsp.read_byte     = rbyte;
      rsp.last_byte     = last;
   end

   // Prefetch the next buffer byte: the following one once data is flowing
   assign rd_idx = (stage_in == SG_DATA) ? (byte_idx_in + 7'd1) : byte_idx_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[fill_ff[BufAw-1:0]] <= item.data;
      end
      rd_data_ff <= buf_mem[rd_idx[BufAw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         stage_ff    <= SG_DEV;
         stop_ff     <= SK_OK;
         tick_ff     <= 16'd0;
         bit_ff      <= 3'd7;
         shift_ff    <= 8'd0;
         byte_idx_ff <= 7'd0;
         retry_ff    <= 8'd0;
         dev_ff      <= 8'd0;
         reg_ff      <= 16'd0;
         wide_ff     <= 1'b0;
         count_ff    <= 7'd0;
         fill_ff     <= 7'd0;
         ack_ff      <= 7'd0;
      end else begin
         phase_ff    <= phase_in;
         stage_ff    <= stage_in;
         stop_ff     <= stop_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         byte_idx_ff <= byte_idx_in;
         retry_ff    <= retry_in;
         dev_ff      <= dev_in;
         reg_ff      <= reg_in;
         wide_ff     <= wide_in;
         count_ff    <= count_in;
         fill_ff     <= fill_in;
         ack_ff      <= ack_in;
      end
   end

endmodule

FILE: rtl/core/i2c_master_transaction_engine_top.sv
// Top level of the I2C master transaction engine.
// Depends on i2cmte_pkg, i2cmte_front, i2cmte_engine, i2cmte_rsp_queue.
//
//  channel  | ports              | transfer when
//  ---------+--------------------+-----------------------------------------
//  request  | req_push/req_full  | req_push & !req_full
//  response | rsp_pop/rsp_empty  | rsp_pop & !rsp_empty
//  csr      | csr_* (APB)        | psel & penable & pwrite (pready high)
//
// One item per clock sustained while the result queue has room; each item's
// result reaches the response ports through the command queue, then an engine
// step into the result queue. The engine handles one item per cycle unless the
// command queue is empty or the result queue is full; the two-entry queues on
// each side let the request and response channels stall independently.
// Reset is synchronous; no clearing pass, the write buffer is not cleared.
module i2c_master_transaction_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_dev_addr,
   input  logic [15:0] req_reg_addr,
   input  logic        req_wide_addr,
   input  logic [6:0]  req_byte_count,
   input  logic [7:0]  req_data_byte,
   input  logic        req_sda_sample,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_scl_drive_low,
   output logic        rsp_sda_drive_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_acked_count,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_last_byte,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import i2cmte_pkg::*;

   logic [7:0]  retry_limit_ff;
   logic [15:0] half_period_ff;
   logic [1:0]  reg_idx;
   logic        csr_wr;
   item_type    item;
   link_type    link;
   logic        link_empty, link_pop;
   rsp_type     rsp_in, rsp_out;
   logic        rsp_push, rsp_full;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = {1'b0, csr_paddr[2]};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 8'd200;
         half_period_ff <= 16'd1;
      end else if (csr_wr) begin
         if (reg_idx == REG_RETRY_LIMIT) begin
            retry_limit_ff <= csr_pwdata[7:0];
         end else begin
            half_period_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_RETRY_LIMIT: csr_prdata = {24'd0, retry_limit_ff};
         REG_HALF_PERIOD: csr_prdata = {16'd0, half_period_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   i2cmte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .opcode     (req_opcode),
      .dev_addr   (req_dev_addr),
      .reg_addr   (req_reg_addr),
      .wide_addr  (req_wide_addr),
      .byte_count (req_byte_count),
      .data_byte  (req_data_byte),
      .sda_sample (req_sda_sample),
      .pop        (link_pop),
      .empty      (link_empty),
      .item       (item)
   );

   assign link.empty = link_empty;
   assign link.pop   = link_pop;

   i2cmte_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .retry_limit       (retry_limit_ff),
      .half_period_ticks (half_period_ff),
      .link_in           (link),
      .link_pop          (link_pop),
      .item              (item),
      .rsp_full          (rsp_full),
      .rsp_push          (rsp_push),
      .rsp               (rsp_in)
   );

   i2cmte_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (rsp_out)
   );

   assign rsp_scl_drive_low = rsp_out.scl_drive_low;
   assign rsp_sda_drive_low = rsp_out.sda_drive_low;
   assign rsp_busy_res      = rsp_out.busy_res;
   assign rsp_done_res      = rsp_out.done_res;
   assign rsp_status        = rsp_out.status;
   assign rsp_acked_count   = rsp_out.acked_count;
   assign rsp_read_valid    = rsp_out.read_valid;
   assign rsp_read_byte     = rsp_out.read_byte;
   assign rsp_last_byte     = rsp_out.last_byte;

endmodule

FILE: test/i2c_master_transaction_engine_top_tb.sv
// Testbench for the I2C master transaction engine top level.
// Predicts each result from a model of the bus engine kept in the bench and
// checks it field by field. Depends on i2cmte_pkg and the top level only.
`timescale 1ns / 100ps

module i2c_master_transaction_engine_top_tb;
   import i2cmte_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int TailCycles    = 8;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  dev;
      logic [15:0] ra;
      logic        wide;
      logic [6:0]  cnt;
      logic [7:0]  data;
      logic        sda;
      rsp_type     exp;
   } cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_opcode = OP_TICK;
   logic [7:0]  req_dev_addr = '0;
   logic [15:0] req_reg_addr = '0;
   logic        req_wide_addr = 1'b0;
   logic [6:0]  req_byte_count = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_sda_sample = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_scl_drive_low, rsp_sda_drive_low, rsp_busy_res, rsp_done_res;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_acked_count;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_byte;
   logic        rsp_last_byte;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cmd_type cmd_q[$];
   rsp_type bus_expect_q[$];
   int      snd_idle = 12, rcv_idle = 59;
   int      stall_left = 0;
   int      err_count = 0, rsp_count = 0, done_count = 0, rbyte_count = 0, nack_count = 0;
   int      quiet_cycles = 0;

   // Bus engine model state
   logic [7:0]    lim_r = 8'd200;
   logic [15:0]   half_r = 16'd1;
   phase_type     ph = PH_IDLE;
   stage_type     stg = SG_DEV;
   stop_kind_type skind = SK_OK;
   logic [15:0]   tcnt = '0;
   logic [2:0]    bidx = 3'd7;
   logic [7:0]    shreg = '0;
   logic [6:0]    bix = '0, fill = '0, acks = '0, lcnt = '0;
   logic [7:0]    rcnt = '0, ldev = '0;
   logic [15:0]   lreg = '0;
   logic          lwide = 1'b0;
   logic [7:0]    wbuf[MaxBurst];
   int            written_hi = 0;
   rsp_type       res;

   i2c_master_transaction_engine_top dut (.*);

   always #10 clock = ~clock;

   // ---------------- model of the bus engine ----------------
   function automatic void load_tx(input logic [7:0] b);
      shreg = b;
      bidx  = 3'd7;
      ph    = PH_TX_LO;
   endfunction

   function automatic void go_stop(input stop_kind_type k);
      skind = k;
      ph    = PH_SP_A;
   endfunction

   function automatic void finish_txn(input logic [1:0] st);
      ph = PH_IDLE;
      tcnt = '0;
      res.done_res = 1'b1;
      res.status = st;
      if (!ldev[0]) fill = '0;
   endfunction

   function automatic void try_attempt();
      if (rcnt >= lim_r) begin
         finish_txn(ST_RETRY);
      end else begin
         rcnt++;
         acks = '0;
         bix = '0;
         stg = SG_DEV;
         tcnt = '0;
         ph = PH_ST_A;
      end
   endfunction

   function automatic void next_data();
      stg = SG_DATA;
      if (bix >= lcnt) go_stop(SK_OK);
      else load_tx(wbuf[bix[5:0]]);
   endfunction

   function automatic void after_ack();
      logic ok;
      ok = (shreg == 8'd0);
      case (stg)
         SG_DEV: begin
            if (!ok) go_stop(SK_RETRY);
            else begin
               stg = lwide ? SG_RHI : SG_RLO;
               load_tx(lwide ? lreg[15:8] : lreg[7:0]);
            end
         end
         SG_RHI: begin
            if (!ok) go_stop(SK_ERR);
            else begin
               acks++;
               stg = SG_RLO;
               load_tx(lreg[7:0]);
            end
         end
         SG_RLO: begin
            if (!ok) go_stop(lwide ? SK_ERR : SK_RETRY);
            else begin
               if (lwide) acks++;
               if (ldev[0]) begin
                  stg = SG_RDEV;
                  ph = PH_RS_A;
               end else next_data();
            end
         end
         SG_RDEV: begin
            if (!ok) go_stop(SK_RETRY);
            else if (lcnt == 0) go_stop(SK_OK);
            else begin
               shreg = '0;
               bidx = 3'd7;
               ph = PH_RX_LO;
            end
         end
         default: begin
            if (!ok) go_stop(SK_ERR);
            else begin
               acks++;
               bix++;
               next_data();
            end
         end
      endcase
   endfunction

   function automatic void advance_bus(input logic sda);
      case (ph)
         PH_RS_A:  ph = PH_ST_A;
         PH_ST_A:  ph = PH_ST_B;
         PH_ST_B:  load_tx(stg == SG_RDEV ? (ldev | 8'h01) : (ldev & 8'hFE));
         PH_TX_LO: ph = PH_TX_HI;
         PH_TX_HI: begin
            if (bidx == 0) ph = PH_ACK_LO;
            else begin
               bidx--;
               ph = PH_TX_LO;
            end
         end
         PH_ACK_LO:  ph = PH_ACK_HI;
         PH_ACK_HI:  begin shreg = {7'd0, sda}; ph = PH_ACK_END; end
         PH_ACK_END: after_ack();
         PH_RX_LO:   ph = PH_RX_HI;
         PH_RX_HI: begin
            shreg = {shreg[6:0], sda};
            if (bidx == 0) begin
               acks++;
               bix++;
               res.read_valid = 1'b1;
               res.read_byte = shreg;
               res.last_byte = (bix >= lcnt);
               ph = res.last_byte ? PH_NA_LO : PH_MA_LO;
            end else begin
               bidx--;
               ph = PH_RX_LO;
            end
         end
         PH_MA_LO:  ph = PH_MA_HI;
         PH_MA_HI:  ph = PH_MA_END;
         PH_MA_END: begin shreg = '0; bidx = 3'd7; ph = PH_RX_LO; end
         PH_NA_LO:  ph = PH_NA_HI;
         PH_NA_HI:  ph = PH_NA_END;
         PH_NA_END: go_stop(SK_OK);
         PH_SP_A:   ph = PH_SP_B;
         PH_SP_B:   ph = PH_SP_C;
         PH_SP_C: begin
            if (skind == SK_RETRY) try_attempt();
            else finish_txn(skind == SK_ERR ? ST_NACK : ST_OK);
         end
         default: ph = PH_IDLE;
      endcase
   endfunction

   function automatic rsp_type predict_item(input cmd_type c);
      logic [15:0] eff;
      logic [6:0]  n;
      res = '0;
      eff = (half_r == 0) ? 16'd1 : half_r;
      if (c.op == OP_TICK) begin
         if (ph != PH_IDLE) begin
            tcnt++;
            if (tcnt >= eff) begin
               tcnt = '0;
               advance_bus(c.sda);
            end
         end
      end else if (ph == PH_IDLE) begin
         if (c.op == OP_LOAD) begin
            if (fill < MaxBurst) begin
               wbuf[fill[5:0]] = c.data;
               fill++;
               if (fill > written_hi) written_hi = fill;
            end
         end else begin
            n = (c.cnt > MaxBurst) ? 7'(MaxBurst) : c.cnt;
            ldev = (c.dev & 8'hFE) | {7'd0, c.op == OP_READ};
            lreg = c.ra;
            lwide = c.wide;
            lcnt = n;
            rcnt = '0;
            try_attempt();
         end
      end
      // line drive held for the current half period
      case (ph)
         PH_RS_A, PH_ACK_LO, PH_RX_LO, PH_NA_LO, PH_NA_END:
            begin res.scl_drive_low = 1; res.sda_drive_low = 0; end
         PH_ST_B, PH_MA_HI, PH_SP_B:
            begin res.scl_drive_low = 0; res.sda_drive_low = 1; end
         PH_TX_LO: begin res.scl_drive_low = 1; res.sda_drive_low = ~shreg[bidx]; end
         PH_TX_HI: begin res.scl_drive_low = 0; res.sda_drive_low = ~shreg[bidx]; end
         PH_ACK_END, PH_MA_LO, PH_MA_END, PH_SP_A:
            begin res.scl_drive_low = 1; res.sda_drive_low = 1; end
         default: begin res.scl_drive_low = 0; res.sda_drive_low = 0; end
      endcase
      res.busy_res = (ph != PH_IDLE);
      if (res.done_res) res.acked_count = acks;
      return res;
   endfunction

   // ---------------- stimulus ----------------
   task automatic send(input logic [1:0] op, input logic [7:0] dev, input logic [15:0] ra,
                       input logic wide, input logic [6:0] cnt, input logic [7:0] data,
                       input logic sda);
      cmd_type c;
      c = '0;
      c.op = op; c.dev = dev; c.ra = ra; c.wide = wide;
      c.cnt = cnt; c.data = data; c.sda = sda;
      c.exp = predict_item(c);
      cmd_q.push_back(c);
   endtask

   // Keep write counts inside the part of the buffer written since reset
   function automatic logic [6:0] safe_count(input logic [6:0] want);
      if (written_hi >= MaxBurst) return want;
      return (want > written_hi) ? 7'(written_hi) : want;
   endfunction

   task automatic noise_item();
      logic [1:0] op;
      logic [6:0] n;
      op = 2'($urandom_range(3, 0));
      n = 7'($urandom_range(127, 0));
      if (op == OP_WRITE) n = safe_count(n);
      send(op, 8'($urandom), 16'($urandom), 1'($urandom), n, 8'($urandom), 1'($urandom));
   endtask

   // Run one transaction to completion; nack_at picks the ACK that is refused,
   // zero for random refusals, or negative for none at all.
   task automatic run_txn(input logic rd, input logic [7:0] dev, input logic [15:0] ra,
                          input logic wide, input logic [6:0] cnt, input int nack_at);
      int ack_no;
      logic sda;
      logic [6:0] n;
      ack_no = 0;
      n = cnt;
      if (!rd) begin
         for (int i = 0; i < cnt; i++)
            send(OP_LOAD, 8'($urandom), '0, 0, '0, 8'($urandom), 0);
         n = safe_count(cnt);
      end
      send(rd ? OP_READ : OP_WRITE, dev, ra, wide, n, 8'($urandom), 1'($urandom));
      while (ph != PH_IDLE) begin
         sda = 1'($urandom);
         if (ph == PH_ACK_HI && int'(tcnt) + 1 >= ((half_r == 0) ? 1 : int'(half_r))) begin
            ack_no++;
            if (nack_at != 0) sda = (ack_no == nack_at);
            else sda = ($urandom_range(99, 0) < 7);
         end
         if ($urandom_range(99, 0) < 3) noise_item();
         send(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 7'($urandom),
              8'($urandom), sda);
      end
   endtask

   task automatic random_txns(input int target);
      int start;
      logic [6:0] n;
      int pick;
      start = cmd_q.size();
      while (cmd_q.size() - start < target) begin
         pick = $urandom_range(99, 0);
         if (pick < 10) begin
            noise_item();
         end else begin
            pick = $urandom_range(99, 0);
            n = (pick < 75) ? 7'($urandom_range(2, 0)) :
                (pick < 97) ? 7'($urandom_range(6, 3)) : 7'($urandom_range(12, 7));
            run_txn(1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom), n, 0);
         end
      end
   endtask

   // Wait until every transfer is back, then let the pipeline settle
   task automatic drain();
      while (cmd_q.size() != 0 || bus_expect_q.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx[0], 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_RETRY_LIMIT) lim_r = val[7:0];
      else half_r = val[15:0];
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      logic took;
      took = req_push && !req_full;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (took) begin
            bus_expect_q.push_back(cmd_q[0].exp);
            void'(cmd_q.pop_front());
         end
         if (req_push && !took) begin
            // hold the offered item until it transfers
         end else if (cmd_q.size() != 0 && $urandom_range(99, 0) >= snd_idle) begin
            req_push <= 1'b1;
            req_opcode <= cmd_q[0].op;
            req_dev_addr <= cmd_q[0].dev;
            req_reg_addr <= cmd_q[0].ra;
            req_wide_addr <= cmd_q[0].wide;
            req_byte_count <= cmd_q[0].cnt;
            req_data_byte <= cmd_q[0].data;
            req_sda_sample <= cmd_q[0].sda;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------- response monitor ----------------
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      err_count++;
      $display("MISMATCH at transfer %0d: %s got %0h expected %0h", rsp_count, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bus_expect_q.size() == 0) begin
               report("unexpected result", 0, 0);
            end else begin
               e = bus_expect_q.pop_front();
               if (rsp_scl_drive_low !== e.scl_drive_low)
                  report("scl_drive_low", rsp_scl_drive_low, e.scl_drive_low);
               if (rsp_sda_drive_low !== e.sda_drive_low)
                  report("sda_drive_low", rsp_sda_drive_low, e.sda_drive_low);
               if (rsp_busy_res !== e.busy_res) report("busy_res", rsp_busy_res, e.busy_res);
               if (rsp_done_res !== e.done_res) report("done_res", rsp_done_res, e.done_res);
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
               if (rsp_acked_count !== e.acked_count)
                  report("acked_count", rsp_acked_count, e.acked_count);
               if (rsp_read_valid !== e.read_valid)
                  report("read_valid", rsp_read_valid, e.read_valid);
               if (rsp_read_byte !== e.read_byte) report("read_byte", rsp_read_byte, e.read_byte);
               if (rsp_last_byte !== e.last_byte) report("last_byte", rsp_last_byte, e.last_byte);
               if (e.done_res) done_count++;
               if (e.done_res && e.status != ST_OK) nack_count++;
               if (e.read_valid) rbyte_count++;
            end
            rsp_count++;
         end
         rsp_pop <= (stall_left == 0) && ($urandom_range(99, 0) >= rcv_idle);
      end
   end

   // Long receiver hold-off so the block backs up onto its input
   always @(posedge clock)
      if (stall_left > 0) stall_left <= stall_left - 1;

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: full buffer and saturated wide write, then the corner cases
      stall_left = 300;
      for (int i = 0; i < MaxBurst; i++)
         send(OP_LOAD, '0, '0, 0, '0, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 0);
      run_txn(0, 8'hFF, 16'hFFFF, 1, 7'd127, -1);
      run_txn(1, 8'h00, 16'h0000, 0, 7'd0, -1);   // read of no bytes
      run_txn(0, 8'h5A, 16'h1234, 0, 7'd0, -1);   // write of addresses only
      run_txn(1, 8'hA0, 16'hBEEF, 1, 7'd3, 1);    // device NACK, then retry
      run_txn(0, 8'hA2, 16'h00F0, 1, 7'd2, 2);    // wide address byte NACK
      run_txn(0, 8'hA4, 16'h0042, 0, 7'd1, 2);    // narrow address NACK retries
      run_txn(0, 8'hA6, 16'h0007, 0, 7'd2, 4);    // data byte NACK
      drain();

      csr_write(REG_RETRY_LIMIT, 32'd3);
      csr_write(REG_HALF_PERIOD, 32'd2);
      random_txns(150);
      drain();

      snd_idle = 59; rcv_idle = 12;
      csr_write(REG_RETRY_LIMIT, 32'd1);
      csr_write(REG_HALF_PERIOD, 32'd1);
      random_txns(150);
      drain();

      snd_idle = 0; rcv_idle = 0;
      csr_write(REG_RETRY_LIMIT, 32'd255);
      csr_write(REG_HALF_PERIOD, 32'd3);
      random_txns(150);
      drain();

      // No attempts allowed, slowest bus: starts end at once, ticks only count
      csr_write(REG_RETRY_LIMIT, 32'd0);
      csr_write(REG_HALF_PERIOD, 32'd65535);
      send(OP_WRITE, 8'h10, 16'h0001, 0, safe_count(7'd2), '0, 0);
      send(OP_READ, 8'h11, 16'h0002, 1, 7'd5, '0, 0);
      drain();
      csr_write(REG_RETRY_LIMIT, 32'd2);
      send(OP_READ, 8'h12, 16'h0003, 0, 7'd1, '0, 0);
      for (int i = 0; i < 30; i++) send(OP_TICK, '0, '0, 0, '0, '0, 1'($urandom));
      drain();

      // Zero half period behaves as one; finishes the open transaction too
      csr_write(REG_HALF_PERIOD, 32'd0);
      while (ph != PH_IDLE) send(OP_TICK, '0, '0, 0, '0, '0, 1'($urandom_range(99, 0) < 10));
      random_txns(100);
      drain();

      $display("Covered %0d transfers: %0d transactions finished, %0d with errors, %0d bytes read.",
               rsp_count, done_count, nack_count, rbyte_count);
      $display("Settings ran from zero to full range on retry limit and half period.");
      if (err_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/i2cmte_pkg.sv
rtl/core/i2cmte_front.sv
rtl/core/i2cmte_rsp_queue.sv
rtl/core/i2cmte_engine.sv
rtl/core/i2c_master_transaction_engine_top.sv
test/i2c_master_transaction_engine_top_tb.sv
